### rtl/sbpd_pkg.sv
// shared constants, types and band edge tables for the spectrum band peak detector
package sbpd_pkg;

	// frame geometry and sample widths
	localparam int BIN_COUNT  = 512;
	localparam int FFT_POINTS = 1024;
	localparam int AMP_WIDTH  = 24;

	localparam int BIN_W      = $clog2(BIN_COUNT);
	localparam int FFT_SHIFT  = $clog2(FFT_POINTS);
	localparam int RATE_W     = 17;
	localparam int BAND_W     = 4;
	localparam int EDGE_W     = 14;
	localparam int PROD_W     = BIN_W + RATE_W;

	// configuration register indexes
	localparam logic REG_BAND_MODE   = 1'b0;
	localparam logic REG_SAMPLE_RATE = 1'b1;

	// band table selection codes
	localparam logic [1:0] MODE_THREE = 2'd0;
	localparam logic [1:0] MODE_FOUR  = 2'd1;
	localparam logic [1:0] MODE_TEN   = 2'd2;

	localparam logic [1:0]        MODE_RESET = MODE_TEN;
	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);

	// one result beat
	typedef struct packed {
		logic [BAND_W-1:0]    band;
		logic [AMP_WIDTH-1:0] peak;
		logic                 done;
		logic                 last;
	} result_t;

	// number of bands in the selected table (unused code behaves as ten bands)
	function automatic logic [BAND_W-1:0] band_count(input logic [1:0] mode);
		logic [BAND_W-1:0] cnt;
		unique case (mode)
			MODE_THREE: cnt = BAND_W'(3);
			MODE_FOUR:  cnt = BAND_W'(4);
			default:    cnt = BAND_W'(10);
		endcase
		return cnt;
	endfunction

	// upper edge in Hz of a band, index clamped to the last band of the table
	function automatic logic [EDGE_W-1:0] band_edge(input logic [1:0] mode,
		input logic [BAND_W-1:0] band);
		logic [BAND_W-1:0] cnt;
		logic [BAND_W-1:0] idx;
		logic [EDGE_W-1:0] edge_hz;
		cnt = band_count(mode);
		idx = (band < cnt) ? band : cnt - BAND_W'(1);
		edge_hz = EDGE_W'(16000);
		unique case (mode)
			MODE_THREE: begin
				unique case (idx)
					BAND_W'(0): edge_hz = EDGE_W'(120);
					BAND_W'(1): edge_hz = EDGE_W'(1000);
					default:    edge_hz = EDGE_W'(16000);
				endcase
			end
			MODE_FOUR: begin
				unique case (idx)
					BAND_W'(0): edge_hz = EDGE_W'(120);
					BAND_W'(1): edge_hz = EDGE_W'(800);
					BAND_W'(2): edge_hz = EDGE_W'(2000);
					default:    edge_hz = EDGE_W'(16000);
				endcase
			end
			default: begin
				unique case (idx)
					BAND_W'(0): edge_hz = EDGE_W'(60);
					BAND_W'(1): edge_hz = EDGE_W'(120);
					BAND_W'(2): edge_hz = EDGE_W'(250);
					BAND_W'(3): edge_hz = EDGE_W'(355);
					BAND_W'(4): edge_hz = EDGE_W'(710);
					BAND_W'(5): edge_hz = EDGE_W'(1420);
					BAND_W'(6): edge_hz = EDGE_W'(2840);
					BAND_W'(7): edge_hz = EDGE_W'(5680);
					BAND_W'(8): edge_hz = EDGE_W'(11360);
					default:    edge_hz = EDGE_W'(16000);
				endcase
			end
		endcase
		return edge_hz;
	endfunction

endpackage

### rtl/spectrum_band_peak_detector_unit.sv
// spectrum band peak detector: per-band peak of a stream of fft bin magnitudes
//
// usage:
//   input channel (in_valid / in_stall / bin_amplitude) takes one fft bin per beat,
//   bin 0 first; bin 0 only restarts the frame, bins 1 .. BIN_COUNT-1 are scored.
//   output channel (out_valid / out_stall / band_number, band_peak, frame_done,
//   last_of_run) gives one beat when a band closes and one for the last bin of a
//   frame (frame_done = 1); the last bin can give two beats.
//   configuration: cfg_wr_en with cfg_index / cfg_wr_data writes band_mode or
//   sample_rate_hz; write only while no beats are pending.
// timing:
//   an accepted bin is scored in the cycle it is accepted (bin frequency by one
//   bin-index times sample-rate multiply); its beats are registered into the result
//   buffer behind any waiting beats. one bin per cycle is sustained; the three-entry
//   result buffer stalls the input only while it holds two or more beats, which
//   happens when the receiver stalls or after a two-beat last bin.
// reset:
//   arst_n clears frame state and empties the result buffer, band_mode returns to ten
//   bands and sample_rate_hz to 44100. while out_stall is high, beats stay in the
//   buffer unchanged and the input stalls once two are waiting.
module spectrum_band_peak_detector_unit
	import sbpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_index,
	input  logic [RATE_W-1:0]    cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [23:0]          bin_amplitude,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [3:0]           band_number,
	output logic [23:0]          band_peak,
	output logic                 frame_done,
	output logic                 last_of_run
);

	// configuration registers
	logic [1:0]        band_mode_q;
	logic [RATE_W-1:0] sample_rate_q;

	// frame state
	logic [BIN_W-1:0]     bin_q;
	logic [BAND_W-1:0]    active_q;
	logic [BAND_W-1:0]    prior_q;
	logic [AMP_WIDTH-1:0] peak_q;

	// result buffer, entry 0 is the output register
	result_t    buf_q [3];
	logic [1:0] count_q;

	// scoring signals
	logic                 accept;
	logic                 pop;
	logic [AMP_WIDTH-1:0] amp;
	logic                 first_bin;
	logic                 close_band;
	logic                 last_bin;
	logic [AMP_WIDTH-1:0] new_peak;
	logic [PROD_W-1:0]    prod;
	logic [PROD_W-1:0]    freq;
	logic [EDGE_W-1:0]    edge_hz;
	logic                 advance;
	logic [1:0]           nres;
	result_t              res0;
	result_t              res1;
	logic [1:0]           base;
	result_t              buf_d [3];

	assign accept = in_valid && !in_stall;
	assign pop    = out_valid && !out_stall;
	assign amp    = bin_amplitude[AMP_WIDTH-1:0];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_mode_q   <= MODE_RESET;
			sample_rate_q <= RATE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BAND_MODE:   band_mode_q   <= cfg_wr_data[1:0];
				REG_SAMPLE_RATE: sample_rate_q <= cfg_wr_data;
				default:         band_mode_q   <= band_mode_q;
			endcase
		end
	end

	// bin scoring: peak update, band closing and band advance
	always_comb begin
		first_bin  = (bin_q == BIN_W'(1));
		close_band = !first_bin && (active_q != prior_q);
		last_bin   = (bin_q == BIN_W'(BIN_COUNT - 1));
		if (first_bin || close_band || amp > peak_q) begin
			new_peak = amp;
		end else begin
			new_peak = peak_q;
		end
		prod    = PROD_W'(bin_q) * PROD_W'(sample_rate_q);
		freq    = prod >> FFT_SHIFT;
		edge_hz = band_edge(band_mode_q, active_q);
		advance = ((active_q + BAND_W'(1)) < band_count(band_mode_q))
			&& (freq > PROD_W'(edge_hz));
	end

	// result beats caused by this bin
	always_comb begin
		res0 = '{band: prior_q, peak: peak_q, done: 1'b0, last: !last_bin};
		res1 = '{band: active_q, peak: new_peak, done: 1'b1, last: 1'b1};
		nres = 2'd0;
		if (bin_q != '0) begin
			if (close_band && last_bin) begin
				nres = 2'd2;
			end else if (close_band || last_bin) begin
				nres = 2'd1;
				if (!close_band) begin
					res0 = res1;
				end
			end
		end
		if (!accept) begin
			nres = 2'd0;
		end
	end

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q    <= '0;
			active_q <= '0;
			prior_q  <= '0;
			peak_q   <= '0;
		end else if (accept) begin
			if (bin_q == '0 || last_bin) begin
				bin_q    <= (bin_q == '0) ? BIN_W'(1) : '0;
				active_q <= '0;
				prior_q  <= '0;
				peak_q   <= '0;
			end else begin
				bin_q    <= bin_q + BIN_W'(1);
				active_q <= advance ? active_q + BAND_W'(1) : active_q;
				prior_q  <= active_q;
				peak_q   <= new_peak;
			end
		end
	end

	// result buffer: shift on pop, new beats land behind what remains
	always_comb begin
		base = count_q - {1'b0, pop};
		for (int i = 0; i < 3; i++) begin
			if (pop && i < 2) begin
				buf_d[i] = buf_q[i+1];
			end else begin
				buf_d[i] = buf_q[i];
			end
			if (nres != 2'd0 && 2'(i) == base) begin
				buf_d[i] = res0;
			end
			if (nres == 2'd2 && 2'(i) == base + 2'd1) begin
				buf_d[i] = res1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			buf_q[i] <= buf_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q - {1'b0, pop} + nres;
		end
	end

	// ports
	assign in_stall    = (count_q > 2'd1);
	assign out_valid   = (count_q != 2'd0);
	assign band_number = buf_q[0].band;
	assign band_peak   = buf_q[0].peak;
	assign frame_done  = buf_q[0].done;
	assign last_of_run = buf_q[0].last;

	// checks
	a_room_for_two: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> count_q <= 2'd1)
		else $error("bin accepted without room for two beats");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && bin_q == BIN_W'(BIN_COUNT - 1) |=> bin_q == '0)
		else $error("frame did not restart after the last bin");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> last_of_run)
		else $error("frame_done beat not marked last_of_run");

	a_bin_zero_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && bin_q == '0 && !pop |=> count_q == $past(count_q))
		else $error("bin zero produced a beat");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the spectrum band peak detector: per-band peaks of a bin stream
module tb_top;
	import sbpd_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int REPORT_TARGET = 48;
	localparam int MIN_BINS      = 1450;
	localparam int MAX_ROUNDS    = 30;
	localparam int MAX_PRINTS    = 100;
	localparam int HOLD_CYCLES   = 400;

	// mode code outside the three tables, decoded as ten bands
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// dut ports, all inputs known from time zero
	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              cfg_wr_en     = 1'b0;
	logic              cfg_index     = REG_BAND_MODE;
	logic [RATE_W-1:0] cfg_wr_data   = '0;
	logic              in_valid      = 1'b0;
	logic              in_stall;
	logic [23:0]       bin_amplitude = '0;
	logic              out_valid;
	logic              out_stall     = 1'b0;
	logic [3:0]        band_number;
	logic [23:0]       band_peak;
	logic              frame_done;
	logic              last_of_run;

	// predictor copy of the registers and the frame state
	logic [1:0]        cur_mode = MODE_RESET;
	logic [RATE_W-1:0] cur_rate = RATE_RESET;
	int unsigned       next_bin = 0;
	logic [3:0]        open_band = '0;
	logic [3:0]        prev_band = '0;
	logic [23:0]       open_peak = '0;
	result_t           pending_reports[$];
	result_t           want;

	int errors        = 0;
	int bins_sent     = 0;
	int reports_seen  = 0;
	int cycles        = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_left     = 0;
	int hold_asks     = 0;
	int holds_done    = 0;

	spectrum_band_peak_detector_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.bin_amplitude (bin_amplitude),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.band_number   (band_number),
		.band_peak     (band_peak),
		.frame_done    (frame_done),
		.last_of_run   (last_of_run)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// receiver: random stall, or a long hold when one is requested
	always @(posedge clk) begin
		if (holds_done != hold_asks) begin
			holds_done = hold_asks;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic flag_mismatch(input string msg);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("tb_top: mismatch at %0t: %s", $time, msg);
	endtask

	// compare each accepted beat against the oldest predicted report
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat band %0d peak %h", band_number, band_peak));
			end else begin
				want = pending_reports.pop_front();
				if (band_number !== want.band)
					flag_mismatch($sformatf("band_number %0d, want %0d", band_number, want.band));
				if (band_peak !== want.peak)
					flag_mismatch($sformatf("band_peak %h, want %h", band_peak, want.peak));
				if (frame_done !== want.done)
					flag_mismatch($sformatf("frame_done %b, want %b", frame_done, want.done));
				if (last_of_run !== want.last)
					flag_mismatch($sformatf("last_of_run %b, want %b", last_of_run, want.last));
			end
		end
	end

	task automatic clear_frame;
		next_bin  = 0;
		open_band = '0;
		prev_band = '0;
		open_peak = '0;
	endtask

	// advance the predicted frame by one accepted bin and queue its reports
	task automatic score_bin(input logic [23:0] amp);
		logic [3:0]  cur;
		int unsigned freq_hz;
		int unsigned nbands;
		int unsigned idx;
		int unsigned top_hz;
		result_t     closed;
		bit          closed_valid;
		bins_sent++;
		if (next_bin == 0) begin
			clear_frame();
			next_bin = 1;
			return;
		end
		cur = open_band;
		closed = '0;
		closed_valid = 1'b0;
		// peak of the open band, closing the previous one on a band change
		if (next_bin == 1) begin
			open_peak = amp;
		end else if (cur != prev_band) begin
			closed = result_t'{band: prev_band, peak: open_peak, done: 1'b0, last: 1'b0};
			closed_valid = 1'b1;
			open_peak = amp;
		end else if (amp > open_peak) begin
			open_peak = amp;
		end
		prev_band = cur;
		// bin frequency against the upper edge of the current band
		freq_hz = (next_bin * cur_rate) / FFT_POINTS;
		case (cur_mode)
			MODE_THREE: nbands = 3;
			MODE_FOUR:  nbands = 4;
			default:    nbands = 10;
		endcase
		idx = (cur < nbands) ? cur : nbands - 1;
		case (nbands)
			3: begin
				case (idx)
					0:       top_hz = 120;
					1:       top_hz = 1000;
					default: top_hz = 16000;
				endcase
			end
			4: begin
				case (idx)
					0:       top_hz = 120;
					1:       top_hz = 800;
					2:       top_hz = 2000;
					default: top_hz = 16000;
				endcase
			end
			default: begin
				case (idx)
					0:       top_hz = 60;
					1:       top_hz = 120;
					2:       top_hz = 250;
					3:       top_hz = 355;
					4:       top_hz = 710;
					5:       top_hz = 1420;
					6:       top_hz = 2840;
					7:       top_hz = 5680;
					8:       top_hz = 11360;
					default: top_hz = 16000;
				endcase
			end
		endcase
		if (cur + 1 < nbands && freq_hz > top_hz)
			open_band = cur + 4'd1;
		// last bin reports the open band with frame_done
		if (next_bin + 1 >= BIN_COUNT) begin
			if (closed_valid)
				pending_reports.push_back(closed);
			pending_reports.push_back(result_t'{band: cur, peak: open_peak, done: 1'b1, last: 1'b1});
			clear_frame();
		end else begin
			if (closed_valid) begin
				closed.last = 1'b1;
				pending_reports.push_back(closed);
			end
			next_bin++;
		end
	endtask

	// amplitudes weighted toward extremes and near-ties
	function automatic logic [23:0] rand_amp();
		case ($urandom_range(0, 9))
			0:       return 24'h000000;
			1:       return 24'hFFFFFF;
			2:       return 24'($urandom_range(0, 15));
			3:       return 24'hFFFFFF - 24'($urandom_range(0, 15));
			default: return 24'($urandom);
		endcase
	endfunction

	// offer one bin beat, with random idle cycles before it
	task automatic send_bin(input logic [23:0] amp);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		bin_amplitude <= amp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		score_bin(amp);
	endtask

	task automatic run_bins(input int count);
		repeat (count)
			send_bin(rand_amp());
	endtask

	task automatic run_to_frame_end;
		while (next_bin != 0)
			send_bin(rand_amp());
	endtask

	// stop input and wait until every predicted report has been taken
	task automatic settle;
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct     = recv_pct;
	endtask

	// write both registers on consecutive edges
	task automatic load_bands(input logic [RATE_W-1:0] mode_word,
		input logic [RATE_W-1:0] rate_word);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= REG_BAND_MODE;
		cfg_wr_data <= mode_word;
		@(posedge clk);
		cur_mode = mode_word[1:0];
		cfg_index   <= REG_SAMPLE_RATE;
		cfg_wr_data <= rate_word;
		@(posedge clk);
		cur_rate = rate_word;
		cfg_wr_en <= 1'b0;
	endtask

	// reset defaults: ignored bin zero, first real bin, early band closes
	task automatic test_directed_bins;
		logic [23:0] amps[20];
		amps = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h800000,
			24'h7FFFFF, 24'h800000, 24'h000001, 24'hAAAAAA, 24'h555555,
			24'hFFFFFE, 24'hFFFFFF, 24'h000000, 24'h000000, 24'h123456,
			24'hFEDCBA, 24'h000001, 24'h000002, 24'h000003, 24'hFFFFFF};
		set_idling(0, 0);
		foreach (amps[i])
			send_bin(amps[i]);
	endtask

	// rest of the frame through all ten bands
	task automatic test_ten_band_frame;
		set_idling(0, 0);
		run_to_frame_end();
	endtask

	// the last bin opens a new band: closed band then final band
	task automatic test_two_beat_last_bin;
		settle();
		set_idling(56, 0);
		load_bands(RATE_W'(MODE_THREE), RATE_W'(2010));
		send_bin(rand_amp());
		run_to_frame_end();
	endtask

	// long receiver hold while bins keep coming, fast band changes
	task automatic test_backpressure_hold;
		settle();
		set_idling(0, 56);
		load_bands({15'($urandom), MODE_TEN}, RATE_W'(131071));
		hold_asks++;
		run_bins(200);
	endtask

	// drop to three bands while a high band is open
	task automatic test_mode_change_mid_frame;
		settle();
		set_idling(21, 21);
		load_bands(RATE_W'(MODE_THREE), RATE_W'(96000));
		run_bins(150);
	endtask

	// unused mode code and a zero rate, across a frame end
	task automatic test_unused_mode_zero_rate;
		settle();
		set_idling(0, 56);
		load_bands(RATE_W'(MODE_UNUSED), RATE_W'(0));
		run_bins(200);
	endtask

	// random settings and idling until enough bins and reports
	task automatic test_random_settings;
		int                round;
		logic [RATE_W-1:0] rate_pick;
		round = 0;
		while ((reports_seen < REPORT_TARGET || bins_sent < MIN_BINS) && round < MAX_ROUNDS) begin
			settle();
			case (round % 4)
				0:       set_idling(0, 0);
				1:       set_idling(56, 0);
				2:       set_idling(0, 56);
				default: set_idling(21, 21);
			endcase
			case ($urandom_range(0, 7))
				0:       rate_pick = '0;
				1:       rate_pick = RATE_W'(131071);
				2:       rate_pick = RATE_W'(8000);
				3:       rate_pick = RATE_W'(96000);
				default: rate_pick = RATE_W'($urandom_range(8000, 96000));
			endcase
			load_bands({15'($urandom), 2'($urandom_range(0, 3))}, rate_pick);
			run_bins(256);
			round++;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_bins();
		test_ten_band_frame();
		test_two_beat_last_bin();
		test_backpressure_hold();
		test_mode_change_mid_frame();
		test_unused_mode_zero_rate();
		test_random_settings();
		// drain and let the output go quiet
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
